// File: rtl/assert_macros.svh
// assertion macros included by the rotated ellipse point plotter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define REP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define REP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rep_pkg.sv
// types, constants and helper functions of the rotated ellipse point plotter
`timescale 1ns / 1ps
package rep_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int COORD_BITS      = 12;

    localparam int ANGLE_W   = 16;
    localparam int RADIUS_W  = 20;
    localparam int CANVAS_W  = 13;
    localparam int COLOR_W   = 24;
    localparam int POS_W     = 18;
    localparam int ADDR_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int TRIG_W    = 16;

    // q30 angle path
    localparam int Q_FRAC  = 30;
    localparam int A_SHIFT = Q_FRAC - ANGLE_FRAC_BITS;
    localparam int A_W     = ANGLE_W + A_SHIFT;
    localparam int R_W     = 31;
    localparam int X2_W    = 32;
    localparam int T_W     = 32;
    localparam int DIV_W   = 8;
    localparam int MAGIC_W = 32;

    localparam logic [A_W-1:0] HALF_PI_Q30  = A_W'(64'd1686629713);
    localparam logic [A_W-1:0] PI_Q30       = A_W'(64'd3373259426);
    localparam logic [A_W-1:0] THREE_HALF_PI_Q30 = A_W'(64'd5059889139);
    localparam logic [A_W-1:0] TWO_PI_Q30   = A_W'(64'd6746518852);
    localparam logic [T_W-1:0] Q30_ONE      = T_W'(64'd1 << Q_FRAC);

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam int CELL_LAT  = 3;
    localparam int SIN_DLY   = (COS_STEPS - SIN_STEPS) * CELL_LAT;

    localparam logic [DIV_W-1:0] SIN_DIV [SIN_STEPS] =
        '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [DIV_W-1:0] COS_DIV [COS_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [MAGIC_W-1:0] SIN_MAGIC [SIN_STEPS] = '{
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)};
    localparam logic [MAGIC_W-1:0] COS_MAGIC [COS_STEPS] = '{
        32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
        32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
        32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAJOR  = 4'd0,
        REG_MINOR  = 4'd1,
        REG_TILT   = 4'd2,
        REG_CX     = 4'd3,
        REG_CY     = 4'd4,
        REG_WIDTH  = 4'd5,
        REG_HEIGHT = 4'd6,
        REG_COLOR  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [R_W-1:0] r;
        logic [1:0]     quad;
    } rep_tag_t;

    typedef struct packed {
        logic                  valid;
        logic [X2_W-1:0]       x2;
        logic signed [T_W-1:0] t;
        rep_tag_t              tag;
    } rep_cell_t;

    // q30 to q1.15, round half away from zero, saturate magnitude
    function automatic logic signed [TRIG_W-1:0] rep_to_q15(input logic signed [T_W:0] v);
        logic [T_W:0] mag;
        logic [T_W:0] q;
        mag = v[T_W] ? (~v + 1'b1) : v;
        q   = (mag + (T_W+1)'(1 << 14)) >> 15;
        if (q > (T_W+1)'(32767)) begin
            q = (T_W+1)'(32767);
        end
        return v[T_W] ? -$signed(q[TRIG_W-1:0]) : $signed(q[TRIG_W-1:0]);
    endfunction

endpackage

// File: rtl/rep_horner_cell.sv
// one horner step of the series: t <= one - ((x2 * t) >> 30) / divisor
`timescale 1ns / 1ps
module rep_horner_cell
    import rep_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rep_cell_t              cell_in,
    input  logic [DIV_W-1:0]       divisor,
    input  logic [MAGIC_W-1:0]     magic,
    output rep_cell_t              cell_out
);

    logic              a_valid_reg;
    logic [X2_W-1:0]   a_p_reg;
    logic [X2_W-1:0]   a_x2_reg;
    rep_tag_t          a_tag_reg;

    logic              b_valid_reg;
    logic [X2_W-1:0]   b_p_reg;
    logic [X2_W-1:0]   b_q0_reg;
    logic [X2_W-1:0]   b_x2_reg;
    rep_tag_t          b_tag_reg;

    rep_cell_t         c_reg;

    logic [62:0]       a_prod;
    logic [63:0]       b_prod;
    logic [39:0]       c_qd;
    logic [39:0]       c_rem;
    logic [X2_W-1:0]   c_q;
    rep_cell_t         c_next;

    // t is never negative on the way in
    assign a_prod = 63'(cell_in.x2) * 63'(cell_in.t[T_W-2:0]);
    // reciprocal estimate, low by at most one
    assign b_prod = 64'(a_p_reg) * 64'(magic);

    always_comb
    begin
        c_qd  = 40'(b_q0_reg) * 40'(divisor);
        c_rem = 40'(b_p_reg) - c_qd;
        c_q   = b_q0_reg + ((c_rem >= 40'(divisor)) ? 32'd1 : 32'd0);
        c_next.valid = b_valid_reg;
        c_next.x2    = b_x2_reg;
        c_next.t     = $signed(Q30_ONE - c_q);
        c_next.tag   = b_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_reg         <= '0;
        end
        else
        begin
            a_valid_reg   <= cell_in.valid;
            b_valid_reg   <= a_valid_reg;
            c_reg         <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p_reg   <= a_prod[61:30];
        a_x2_reg  <= cell_in.x2;
        a_tag_reg <= cell_in.tag;
        b_p_reg   <= a_p_reg;
        b_q0_reg  <= b_prod[63:32];
        b_x2_reg  <= a_x2_reg;
        b_tag_reg <= a_tag_reg;
    end

    assign cell_out = c_reg;

endmodule

// File: rtl/rep_sincos.sv
// pipelined q1.15 sine and cosine: range reduction, two rows of horner cells
`timescale 1ns / 1ps
module rep_sincos
    import rep_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [ANGLE_W-1:0]       angle,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] sin_q15,
    output logic signed [TRIG_W-1:0] cos_q15
);

    logic              s1_valid_reg;
    logic [R_W-1:0]    s1_r_reg;
    logic [1:0]        s1_quad_reg;
    rep_cell_t         s2_reg;

    logic [A_W-1:0]    s1_a;
    logic [A_W-1:0]    s1_am;
    logic [A_W-1:0]    s1_base;
    logic [1:0]        s1_quad;
    logic [A_W-1:0]    s1_r;
    logic [61:0]       s2_sq;

    rep_cell_t         sin_bus [SIN_STEPS+1];
    rep_cell_t         cos_bus [COS_STEPS+1];

    logic [61:0]       f_prod;
    logic [T_W-1:0]    sin_dly_reg [SIN_DLY];

    logic                     o_valid_reg;
    logic signed [TRIG_W-1:0] o_sin_reg;
    logic signed [TRIG_W-1:0] o_cos_reg;
    logic signed [TRIG_W-1:0] o_sr;
    logic signed [TRIG_W-1:0] o_cr;
    logic signed [TRIG_W-1:0] o_sin_next;
    logic signed [TRIG_W-1:0] o_cos_next;

    // wrap into one turn, then fold into the first quadrant
    always_comb
    begin
        s1_a  = {angle, A_SHIFT'(0)};
        s1_am = (s1_a >= TWO_PI_Q30) ? s1_a - TWO_PI_Q30 : s1_a;
        priority if (s1_am >= THREE_HALF_PI_Q30)
        begin
            s1_quad = QUAD_IV;
            s1_base = THREE_HALF_PI_Q30;
        end
        else if (s1_am >= PI_Q30)
        begin
            s1_quad = QUAD_III;
            s1_base = PI_Q30;
        end
        else if (s1_am >= HALF_PI_Q30)
        begin
            s1_quad = QUAD_II;
            s1_base = HALF_PI_Q30;
        end
        else
        begin
            s1_quad = QUAD_I;
            s1_base = '0;
        end
        s1_r = s1_am - s1_base;
    end

    assign s2_sq = 62'(s1_r_reg) * 62'(s1_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_reg       <= '0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= in_valid;
            s2_reg.valid    <= s1_valid_reg;
            s2_reg.x2       <= s2_sq[61:30];
            s2_reg.t        <= $signed(Q30_ONE);
            s2_reg.tag.r    <= s1_r_reg;
            s2_reg.tag.quad <= s1_quad_reg;
            o_valid_reg     <= cos_bus[COS_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg        <= s1_r[R_W-1:0];
        s1_quad_reg     <= s1_quad;
    end

    assign sin_bus[0] = s2_reg;
    assign cos_bus[0] = s2_reg;

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        rep_horner_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (sin_bus[i]),
            .divisor  (SIN_DIV[i]),
            .magic    (SIN_MAGIC[i]),
            .cell_out (sin_bus[i+1])
        );
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        rep_horner_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (cos_bus[i]),
            .divisor  (COS_DIV[i]),
            .magic    (COS_MAGIC[i]),
            .cell_out (cos_bus[i+1])
        );
    end

    // sine needs the final x * t, then waits for the longer cosine row
    assign f_prod = 62'(sin_bus[SIN_STEPS].tag.r) * 62'(sin_bus[SIN_STEPS].t[T_W-2:0]);

    always_ff @(posedge clk)
    begin
        sin_dly_reg[0] <= {2'b00, f_prod[59:30]} | {f_prod[61:60], 30'd0};
        for (int i = 1; i < SIN_DLY; i++)
        begin
            sin_dly_reg[i] <= sin_dly_reg[i-1];
        end
    end

    always_comb
    begin
        o_sr = rep_to_q15($signed({1'b0, sin_dly_reg[SIN_DLY-1]}));
        o_cr = rep_to_q15($signed({cos_bus[COS_STEPS].t[T_W-1], cos_bus[COS_STEPS].t}));
        unique case (cos_bus[COS_STEPS].tag.quad)
            QUAD_I:
            begin
                o_sin_next = o_sr;
                o_cos_next = o_cr;
            end
            QUAD_II:
            begin
                o_sin_next = o_cr;
                o_cos_next = -o_sr;
            end
            QUAD_III:
            begin
                o_sin_next = -o_sr;
                o_cos_next = -o_cr;
            end
            default:
            begin
                o_sin_next = -o_cr;
                o_cos_next = o_sr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        o_sin_reg <= o_sin_next;
        o_cos_reg <= o_cos_next;
    end

    assign out_valid = o_valid_reg;
    assign sin_q15   = o_sin_reg;
    assign cos_q15   = o_cos_reg;

endmodule

// File: rtl/rotated_ellipse_point_plotter.sv
// rotated ellipse point plotter: ellipse point, clipping and pixel address
// usage:
//   write the registers through cfg_wr_en / cfg_index / cfg_data while idle;
//   index 0..7 selects major, minor, tilt, center x, center y, width,
//   height and color; other indexes are dropped
//   an angle transfer happens at each rising edge with start high and busy
//   low; busy stays low, so a new angle can be given every cycle
//   each angle gives one result, shown for one cycle with done high,
//   taken at the 26th rising edge after the transfer, in the order of the angles
//   throughput is one point per clock: every stage is a register
//   row of horner cells (six cells of three stages for the cosine) and
//   the multiplier stages behind them
//   a result cannot be held off: the receiver must take it when done is high
//   reset clears all pipeline valids (in-flight points are dropped) and
//   restores the register defaults (canvas 1024 x 1024, all else zero)
//   when a point is off the canvas, pixel_address and pixel_color read zero
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotated_ellipse_point_plotter
    import rep_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  logic [ANGLE_W-1:0]       angle,
    output logic                     done,
    output logic signed [POS_W-1:0]  x_pos,
    output logic signed [POS_W-1:0]  y_pos,
    output logic                     visible,
    output logic [ADDR_W-1:0]        pixel_address,
    output logic [COLOR_W-1:0]       pixel_color
);

    localparam int P1_W = 37;
    localparam int P2_W = 53;
    localparam int P3_W = 54;
    localparam int XY_W = 20;
    localparam logic signed [P3_W-1:0] TRUNC_BIAS = (P3_W'(1) << 34) - P3_W'(1);
    localparam logic signed [XY_W-1:0] POS_MAX = XY_W'(131071);
    localparam logic signed [XY_W-1:0] POS_MIN = -XY_W'(131072);

    logic [RADIUS_W-1:0]   major_radius_reg;
    logic [RADIUS_W-1:0]   minor_radius_reg;
    logic [ANGLE_W-1:0]    tilt_angle_reg;
    logic [COORD_BITS-1:0] center_x_reg;
    logic [COORD_BITS-1:0] center_y_reg;
    logic [CANVAS_W-1:0]   canvas_width_reg;
    logic [CANVAS_W-1:0]   canvas_height_reg;
    logic [COLOR_W-1:0]    plot_color_reg;

    logic                     accept;
    logic                     ang_valid;
    logic                     tilt_valid;
    logic signed [TRIG_W-1:0] sin_a;
    logic signed [TRIG_W-1:0] cos_a;
    logic signed [TRIG_W-1:0] sin_t;
    logic signed [TRIG_W-1:0] cos_t;

    logic                     p1_valid_reg;
    logic signed [P1_W-1:0]   p1_rc_reg;
    logic signed [P1_W-1:0]   p1_rs_reg;
    logic signed [TRIG_W-1:0] p1_ct_reg;
    logic signed [TRIG_W-1:0] p1_st_reg;

    logic                     p2_valid_reg;
    logic signed [P2_W-1:0]   p2_cc_reg;
    logic signed [P2_W-1:0]   p2_cs_reg;
    logic signed [P2_W-1:0]   p2_ss_reg;
    logic signed [P2_W-1:0]   p2_sc_reg;

    logic                     p3_valid_reg;
    logic signed [P3_W-1:0]   p3_xs_reg;
    logic signed [P3_W-1:0]   p3_ys_reg;

    logic                     p4_valid_reg;
    logic signed [XY_W-1:0]   p4_x_reg;
    logic signed [XY_W-1:0]   p4_y_reg;

    logic signed [P3_W-1:0]   p4_xb;
    logic signed [P3_W-1:0]   p4_yb;
    logic signed [XY_W-1:0]   p4_x_next;
    logic signed [XY_W-1:0]   p4_y_next;

    logic                     p5_vis;
    logic signed [XY_W-1:0]   p5_xs;
    logic signed [XY_W-1:0]   p5_ys;
    logic [25:0]              p5_addr;

    logic                     done_reg;
    logic signed [POS_W-1:0]  x_pos_reg;
    logic signed [POS_W-1:0]  y_pos_reg;
    logic                     visible_reg;
    logic [ADDR_W-1:0]        pixel_address_reg;
    logic [COLOR_W-1:0]       pixel_color_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_radius_reg  <= '0;
            minor_radius_reg  <= '0;
            tilt_angle_reg    <= '0;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            canvas_width_reg  <= CANVAS_W'(1024);
            canvas_height_reg <= CANVAS_W'(1024);
            plot_color_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MAJOR:  major_radius_reg  <= cfg_data[RADIUS_W-1:0];
                REG_MINOR:  minor_radius_reg  <= cfg_data[RADIUS_W-1:0];
                REG_TILT:   tilt_angle_reg    <= cfg_data[ANGLE_W-1:0];
                REG_CX:     center_x_reg      <= cfg_data[COORD_BITS-1:0];
                REG_CY:     center_y_reg      <= cfg_data[COORD_BITS-1:0];
                REG_WIDTH:  canvas_width_reg  <= cfg_data[CANVAS_W-1:0];
                REG_HEIGHT: canvas_height_reg <= cfg_data[CANVAS_W-1:0];
                REG_COLOR:  plot_color_reg    <= cfg_data[COLOR_W-1:0];
                default:    ;
            endcase
        end
    end

    // the tilt runs through its own unit alongside each angle
    rep_sincos u_ang (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (angle),
        .out_valid (ang_valid),
        .sin_q15   (sin_a),
        .cos_q15   (cos_a)
    );

    rep_sincos u_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (tilt_angle_reg),
        .out_valid (tilt_valid),
        .sin_q15   (sin_t),
        .cos_q15   (cos_t)
    );

    // truncate offsets toward zero, then add the center
    always_comb
    begin
        p4_xb     = p3_xs_reg + (p3_xs_reg[P3_W-1] ? TRUNC_BIAS : P3_W'(0));
        p4_yb     = p3_ys_reg + (p3_ys_reg[P3_W-1] ? TRUNC_BIAS : P3_W'(0));
        p4_x_next = p4_xb[P3_W-1:34] + $signed(XY_W'(center_x_reg));
        p4_y_next = p4_yb[P3_W-1:34] + $signed(XY_W'(center_y_reg));
    end

    always_comb
    begin
        p5_vis = !p4_x_reg[XY_W-1] && !p4_y_reg[XY_W-1]
              && (p4_x_reg < $signed(XY_W'(canvas_width_reg)))
              && (p4_y_reg < $signed(XY_W'(canvas_height_reg)));
        priority if (p4_x_reg > POS_MAX)
            p5_xs = POS_MAX;
        else if (p4_x_reg < POS_MIN)
            p5_xs = POS_MIN;
        else
            p5_xs = p4_x_reg;
        priority if (p4_y_reg > POS_MAX)
            p5_ys = POS_MAX;
        else if (p4_y_reg < POS_MIN)
            p5_ys = POS_MIN;
        else
            p5_ys = p4_y_reg;
        p5_addr = 26'(p4_y_reg[CANVAS_W-1:0]) * 26'(canvas_width_reg)
                + 26'(p4_x_reg[CANVAS_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= ang_valid && tilt_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            done_reg     <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_rc_reg <= $signed({1'b0, major_radius_reg}) * cos_a;
        p1_rs_reg <= $signed({1'b0, minor_radius_reg}) * sin_a;
        p1_ct_reg <= cos_t;
        p1_st_reg <= sin_t;
        p2_cc_reg <= p1_rc_reg * p1_ct_reg;
        p2_cs_reg <= p1_rc_reg * p1_st_reg;
        p2_ss_reg <= p1_rs_reg * p1_st_reg;
        p2_sc_reg <= p1_rs_reg * p1_ct_reg;
        p3_xs_reg <= P3_W'(p2_cc_reg) - P3_W'(p2_ss_reg);
        p3_ys_reg <= P3_W'(p2_cs_reg) + P3_W'(p2_sc_reg);
        p4_x_reg  <= p4_x_next;
        p4_y_reg  <= p4_y_next;
        x_pos_reg         <= p5_xs[POS_W-1:0];
        y_pos_reg         <= p5_ys[POS_W-1:0];
        visible_reg       <= p5_vis;
        pixel_address_reg <= p5_vis ? p5_addr[ADDR_W-1:0] : '0;
        pixel_color_reg   <= p5_vis ? plot_color_reg : '0;
    end

    assign done          = done_reg;
    assign x_pos         = x_pos_reg;
    assign y_pos         = y_pos_reg;
    assign visible       = visible_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_color   = pixel_color_reg;

    `REP_ASSERT_IMP(a_lanes_aligned, clk, rst_n, 1'b1, ang_valid == tilt_valid, "angle and tilt lanes out of step")
    `REP_ASSERT_IMP(a_hidden_zero, clk, rst_n, done && !visible, (pixel_address == '0) && (pixel_color == '0), "hidden point carries address or color")
    `REP_ASSERT_NXT(a_last_stage, clk, rst_n, p4_valid_reg, done && (visible == $past(p5_vis)), "result transfer lost at output")

endmodule

// File: tb/tb.sv
// testbench for the rotated ellipse point plotter: edge and random angles checked against a scoreboard
`timescale 1ns / 1ps
module tb;
    import rep_pkg::*;

    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = 4'd11;
    localparam longint HALF_PI = 64'd1686629713;
    localparam longint TWO_PI  = 64'd6746518852;
    localparam longint ONE_Q30 = 64'd1 << 30;
    localparam int     PIPE_LAT = 26;

    typedef struct {
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic                    visible;
        logic [ADDR_W-1:0]       pixel_address;
        logic [COLOR_W-1:0]      pixel_color;
    } point_t;

    class point_board;
        longint major, minor, tilt, cx, cy, width, height, color;
        point_t pending[$];
        int     errors;

        function void clear_regs();
            major = 0; minor = 0; tilt = 0; cx = 0; cy = 0;
            width = 1024; height = 1024; color = 0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAJOR:  major  = data[19:0];
                REG_MINOR:  minor  = data[19:0];
                REG_TILT:   tilt   = data[15:0];
                REG_CX:     cx     = data[11:0];
                REG_CY:     cy     = data[11:0];
                REG_WIDTH:  width  = data[12:0];
                REG_HEIGHT: height = data[12:0];
                REG_COLOR:  color  = data[23:0];
                default: ;
            endcase
        endfunction

        // horner series, sine to x^11 and cosine to x^12, all in q30
        function longint series(longint r, bit is_sin);
            longint x2, t;
            longint dv[6];
            int n;
            x2 = (r * r) >>> 30;
            t = ONE_Q30;
            if (is_sin)
            begin
                dv = '{110, 72, 42, 20, 6, 1};
                n = 5;
            end
            else
            begin
                dv = '{132, 90, 56, 30, 12, 2};
                n = 6;
            end
            for (int i = 0; i < n; i++)
                t = ONE_Q30 - ((x2 * t) >>> 30) / dv[i];
            return is_sin ? (r * t) >>> 30 : t;
        endfunction

        function longint q15(longint v);
            longint mag, q;
            mag = v < 0 ? -v : v;
            q = (mag + 16384) >>> 15;
            if (q > 32767)
                q = 32767;
            return v < 0 ? -q : q;
        endfunction

        function void sincos(longint ang, output longint s, output longint c);
            longint a, sr, cr;
            int quad;
            a = (ang << 17) % TWO_PI;
            quad = 0;
            while (quad < 3 && a >= HALF_PI)
            begin
                a -= HALF_PI;
                quad++;
            end
            sr = q15(series(a, 1));
            cr = q15(series(a, 0));
            case (quad)
                0: begin s = sr;  c = cr;  end
                1: begin s = cr;  c = -sr; end
                2: begin s = -sr; c = -cr; end
                default: begin s = -cr; c = sr; end
            endcase
        endfunction

        function void note_angle(logic [ANGLE_W-1:0] ang);
            longint sa, ca, st, ct, x, y;
            point_t p;
            sincos(ang, sa, ca);
            sincos(tilt, st, ct);
            x = (major * ca * ct - minor * sa * st) / (longint'(1) << 34) + cx;
            y = (major * ca * st + minor * sa * ct) / (longint'(1) << 34) + cy;
            p.visible = x >= 0 && y >= 0 && x < width && y < height;
            p.x_pos = POS_W'(x > 131071 ? 131071 : (x < -131072 ? -131072 : x));
            p.y_pos = POS_W'(y > 131071 ? 131071 : (y < -131072 ? -131072 : y));
            p.pixel_address = p.visible ? ADDR_W'(y * width + x) : '0;
            p.pixel_color = p.visible ? COLOR_W'(color) : '0;
            pending.push_back(p);
        endfunction

        function void flag(string what, longint exp_v, longint act_v);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
        endfunction

        function void check_point(point_t got);
            point_t e;
            if (pending.size() == 0)
            begin
                flag("unexpected point", 0, 1);
                return;
            end
            e = pending.pop_front();
            if (got.x_pos !== e.x_pos) flag("x_pos", e.x_pos, got.x_pos);
            if (got.y_pos !== e.y_pos) flag("y_pos", e.y_pos, got.y_pos);
            if (got.visible !== e.visible) flag("visible", e.visible, got.visible);
            if (got.pixel_address !== e.pixel_address)
                flag("pixel_address", e.pixel_address, got.pixel_address);
            if (got.pixel_color !== e.pixel_color)
                flag("pixel_color", e.pixel_color, got.pixel_color);
        endfunction
    endclass

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    start = 0;
    logic                    busy;
    logic [ANGLE_W-1:0]      angle = '0;
    logic                    done;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic                    visible;
    logic [ADDR_W-1:0]       pixel_address;
    logic [COLOR_W-1:0]      pixel_color;

    point_board board = new();
    bit gaps_on = 1;

    rotated_ellipse_point_plotter u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .angle(angle),
        .done(done), .x_pos(x_pos), .y_pos(y_pos), .visible(visible),
        .pixel_address(pixel_address), .pixel_color(pixel_color)
    );

    always #4 clk = ~clk;

    // transfers and results seen with pre-edge values
    always @(posedge clk)
    begin
        point_t got;
        if (rst_n && start && !busy)
            board.note_angle(angle);
        if (rst_n && done)
        begin
            got.x_pos = x_pos;
            got.y_pos = y_pos;
            got.visible = visible;
            got.pixel_address = pixel_address;
            got.pixel_color = pixel_color;
            board.check_point(got);
        end
    end

    task automatic send_angle(logic [ANGLE_W-1:0] a);
        int gap;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        angle <= a;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves cfg_wr_en high; caller lowers it after the batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic load_regs(int unsigned mj, int unsigned mn, int unsigned tl,
                             int unsigned x0, int unsigned y0, int unsigned w,
                             int unsigned h, int unsigned col);
        write_reg(REG_MAJOR, CFG_DATA_W'(mj));
        write_reg(REG_MINOR, CFG_DATA_W'(mn));
        write_reg(REG_TILT, CFG_DATA_W'(tl));
        write_reg(REG_CX, CFG_DATA_W'(x0));
        write_reg(REG_CY, CFG_DATA_W'(y0));
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_COLOR, CFG_DATA_W'(col));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [ANGLE_W-1:0] edges[$];
        int unsigned mj, mn;
        board.clear_regs();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults first, then wide open settings
        edges = '{16'd0, 16'd1, 16'd12867, 16'd12868, 16'd25735, 16'd25736,
                  16'd38603, 16'd38604, 16'd51471, 16'd51472, 16'd32768, 16'd65535};
        foreach (edges[i]) send_angle(edges[i]);
        drain();
        load_regs(20'hFFFFF, 20'hFFFFF, 16'd51471, 12'd4095, 12'd4095, 13'd4096,
                  13'd4096, 24'hFFFFFF);
        foreach (edges[i]) send_angle(edges[i]);
        drain();
        // zero canvas, oversize canvas, ignored index, masked high data bits
        load_regs(20'd4000, 20'd1600, 16'd6000, 12'd100, 12'd100, 13'd0, 13'd8191,
                  24'h123456);
        write_reg(SPARE_INDEX, 24'hFFFFFF);
        write_reg(REG_CX, 24'hFFF064);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        send_angle(16'd0);
        send_angle(16'd20000);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph < 2)
            begin
                mj = ph == 0 ? 0 : 20'hFFFFF;
                mn = ph == 0 ? 20'hFFFFF : 0;
            end
            else
            begin
                mj = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                 : $urandom_range(0, 20000);
                mn = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                 : $urandom_range(0, 20000);
            end
            load_regs(mj, mn, $urandom_range(0, 16'hFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF),
                      ph == 3 ? 1 : (ph == 4 ? 13'd8191 : $urandom_range(1, 4096)),
                      ph == 3 ? 13'd8191 : (ph == 4 ? 1 : $urandom_range(1, 4096)),
                      $urandom_range(0, 24'hFFFFFF));
            for (int i = 0; i < 102; i++)
            begin
                if (i % 34 == 0)
                    gaps_on = $urandom_range(0, 2) != 0;
                send_angle(ANGLE_W'($urandom_range(0, 16'hFFFF)));
            end
            gaps_on = 1;
            drain();
        end

        repeat (PIPE_LAT + 10) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS rotated_ellipse_point_plotter");
        else
            $display("FAIL rotated_ellipse_point_plotter");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAIL rotated_ellipse_point_plotter");
        $finish;
    end
endmodule
